// File: design/segment_box_intersect_top_assert.svh
// ----------------------------------------------------------------------------
// segment box intersect assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef SEGMENT_BOX_INTERSECT_TOP_ASSERT_SVH
`define SEGMENT_BOX_INTERSECT_TOP_ASSERT_SVH

// condition must never hold out of reset
`define SBI_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define SBI_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/sbi_pkg.sv
// ----------------------------------------------------------------------------
// sbi_pkg
// fixed-point constants and types for the segment box slab test
// ----------------------------------------------------------------------------
package sbi_pkg;

    localparam int T_FRAC  = 24;               // fraction bits of a parameter
    localparam int T_IBITS = 7;                // integer bits below saturation
    localparam int T_QBITS = T_FRAC + T_IBITS; // quotient bits, one per stage
    localparam int T_WIDTH = T_QBITS + 2;      // signed parameter width

    localparam logic signed [T_WIDTH-1:0] T_ZERO    = '0;
    localparam logic signed [T_WIDTH-1:0] T_ONE     = T_WIDTH'(1) <<< T_FRAC;
    localparam logic signed [T_WIDTH-1:0] T_SAT_POS = (T_WIDTH'(1) <<< T_QBITS) - T_WIDTH'(1);
    localparam logic signed [T_WIDTH-1:0] T_SAT_NEG = -(T_WIDTH'(1) <<< T_QBITS);

    localparam int N_AXES  = 3;
    localparam int N_LANES = 2 * N_AXES;

    // per-axis flags that ride along with the divider pipeline
    typedef struct packed {
        logic [N_AXES-1:0] flat; // segment does not move on this axis
        logic [N_AXES-1:0] ok;   // start lies inside the bounds
    } t_side;

endpackage

// File: design/segment_box_intersect_top.sv
// ----------------------------------------------------------------------------
// segment box intersect
// pipelined slab test of a line segment against an axis-aligned box
// ----------------------------------------------------------------------------
// One request enters per clock whenever start is high; busy never rises, so
// the block takes a new request in every cycle. Each request yields exactly
// one result, o_hit with o_valid, in request order; the receiver cannot
// hold it off. The latency is set by the six restoring dividers, one
// quotient bit per stage (31 stages for a Q8.24 parameter), plus three
// stages ahead for bounds, numerators and saturation and three behind for
// sign, ordering and the interval reduction. Boundary touches count as
// hits.
// ----------------------------------------------------------------------------
module segment_box_intersect_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_z,
    input  logic signed [COORD_WIDTH-1:0] i_box_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_center_z,
    input  logic        [COORD_WIDTH-2:0] i_box_half_x,
    input  logic        [COORD_WIDTH-2:0] i_box_half_y,
    input  logic        [COORD_WIDTH-2:0] i_box_half_z,
    output logic                          o_valid,
    output logic                          o_hit
);
    import sbi_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int QB      = T_QBITS;
    localparam int LATENCY = QB + 6;

    // ---------------------------------------------------------------- stage 1
    // box bounds and direction, one bit wider than a coordinate
    logic signed [W-1:0] w_p0 [N_AXES];
    logic signed [W-1:0] w_p1 [N_AXES];
    logic signed [W-1:0] w_c  [N_AXES];
    logic        [W-2:0] w_h  [N_AXES];

    assign w_p0[0] = i_start_x;      assign w_p0[1] = i_start_y;      assign w_p0[2] = i_start_z;
    assign w_p1[0] = i_end_x;        assign w_p1[1] = i_end_y;        assign w_p1[2] = i_end_z;
    assign w_c[0]  = i_box_center_x; assign w_c[1]  = i_box_center_y; assign w_c[2]  = i_box_center_z;
    assign w_h[0]  = i_box_half_x;   assign w_h[1]  = i_box_half_y;   assign w_h[2]  = i_box_half_z;

    logic                r_v1;
    logic signed [W:0]   r1_lo [N_AXES];
    logic signed [W:0]   r1_hi [N_AXES];
    logic signed [W:0]   r1_d  [N_AXES];
    logic signed [W-1:0] r1_p0 [N_AXES];
    logic signed [W:0]   n1_lo [N_AXES];
    logic signed [W:0]   n1_hi [N_AXES];
    logic signed [W:0]   n1_d  [N_AXES];

    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            n1_lo[a] = $signed({w_c[a][W-1], w_c[a]}) - $signed({2'b00, w_h[a]});
            n1_hi[a] = $signed({w_c[a][W-1], w_c[a]}) + $signed({2'b00, w_h[a]});
            n1_d[a]  = $signed({w_p1[a][W-1], w_p1[a]}) - $signed({w_p0[a][W-1], w_p0[a]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        for (int a = 0; a < N_AXES; a++) begin
            r1_lo[a] <= n1_lo[a];
            r1_hi[a] <= n1_hi[a];
            r1_d[a]  <= n1_d[a];
            r1_p0[a] <= w_p0[a];
        end
    end

    // ---------------------------------------------------------------- stage 2
    // numerators, magnitudes and signs; flat-axis containment test
    // lane 2a is the low bound of axis a, lane 2a+1 the high bound
    logic                r_v2;
    t_side               r2_side;
    t_side               n2_side;
    logic [W+1:0]        r2_an  [N_LANES];
    logic [W:0]          r2_ad  [N_LANES];
    logic                r2_neg [N_LANES];
    logic [W+1:0]        n2_an  [N_LANES];
    logic [W:0]          n2_ad  [N_LANES];
    logic                n2_neg [N_LANES];
    logic signed [W+1:0] w2_num [N_LANES];
    logic signed [W:0]   w2_p0  [N_AXES];

    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            w2_p0[a]         = $signed({r1_p0[a][W-1], r1_p0[a]});
            n2_side.flat[a]  = (r1_d[a] == '0);
            n2_side.ok[a]    = !((w2_p0[a] < r1_lo[a]) || (w2_p0[a] > r1_hi[a]));
            w2_num[2*a]      = $signed({r1_lo[a][W], r1_lo[a]}) - $signed({w2_p0[a][W], w2_p0[a]});
            w2_num[2*a+1]    = $signed({r1_hi[a][W], r1_hi[a]}) - $signed({w2_p0[a][W], w2_p0[a]});
            for (int s = 0; s < 2; s++) begin
                n2_an[2*a+s]  = w2_num[2*a+s][W+1] ? (W+2)'(-w2_num[2*a+s])
                                                   : (W+2)'(w2_num[2*a+s]);
                n2_ad[2*a+s]  = r1_d[a][W] ? (W+1)'(-r1_d[a]) : (W+1)'(r1_d[a]);
                n2_neg[2*a+s] = w2_num[2*a+s][W+1] ^ r1_d[a][W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r2_side <= n2_side;
        for (int l = 0; l < N_LANES; l++) begin
            r2_an[l]  <= n2_an[l];
            r2_ad[l]  <= n2_ad[l];
            r2_neg[l] <= n2_neg[l];
        end
    end

    // ------------------------------------------------------- divider pipeline
    // index 0 is loaded with the saturation flag and the leading remainder;
    // index k+1 holds the state after quotient bit QB-1-k
    logic                 r_dv   [0:QB];
    t_side                r_side [0:QB];
    logic [W:0]           r_rem  [0:QB][N_LANES];
    logic [QB-1:0]        r_q    [0:QB][N_LANES];
    logic [W:0]           r_ad   [0:QB][N_LANES];
    logic [T_IBITS-1:0]   r_anlo [0:QB][N_LANES];
    logic                 r_neg  [0:QB][N_LANES];
    logic                 r_sat  [0:QB][N_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_v2;
        end
        r_side[0] <= r2_side;
        for (int l = 0; l < N_LANES; l++) begin
            // quotient reaches 128.0 or more
            r_sat[0][l]  <= ({6'b0, r2_an[l]} >= {r2_ad[l], {T_IBITS{1'b0}}});
            r_rem[0][l]  <= (W+1)'(r2_an[l] >> T_IBITS);
            r_q[0][l]    <= '0;
            r_ad[0][l]   <= r2_ad[l];
            r_anlo[0][l] <= r2_an[l][T_IBITS-1:0];
            r_neg[0][l]  <= r2_neg[l];
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int BI = QB - 1 - k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else begin
                r_dv[k+1] <= r_dv[k];
            end
            r_side[k+1] <= r_side[k];
        end

        for (genvar l = 0; l < N_LANES; l++) begin : g_lane
            logic         w_nbit;
            logic [W+1:0] n_shift;
            logic         n_ge;

            if (BI >= T_FRAC) begin : g_bit
                assign w_nbit = r_anlo[k][l][BI-T_FRAC];
            end else begin : g_zero
                assign w_nbit = 1'b0;
            end

            assign n_shift = {r_rem[k][l], w_nbit};
            assign n_ge    = (n_shift >= {1'b0, r_ad[k][l]});

            always_ff @(posedge i_clk) begin
                r_rem[k+1][l]  <= n_ge ? (W+1)'(n_shift - {1'b0, r_ad[k][l]})
                                       : (W+1)'(n_shift);
                r_q[k+1][l]    <= {r_q[k][l][QB-2:0], n_ge};
                r_ad[k+1][l]   <= r_ad[k][l];
                r_anlo[k+1][l] <= r_anlo[k][l];
                r_neg[k+1][l]  <= r_neg[k][l];
                r_sat[k+1][l]  <= r_sat[k][l];
            end
        end
    end

    // ---------------------------------------------------------------- stage F
    // apply sign and saturation to form Q8.24 parameters
    logic                      r_vf;
    t_side                     rf_side;
    logic signed [T_WIDTH-1:0] rf_t [N_LANES];
    logic signed [T_WIDTH-1:0] nf_t [N_LANES];

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            if (r_sat[QB][l]) begin
                nf_t[l] = r_neg[QB][l] ? T_SAT_NEG : T_SAT_POS;
            end else if (r_neg[QB][l]) begin
                nf_t[l] = -$signed({2'b00, r_q[QB][l]});
            end else begin
                nf_t[l] = $signed({2'b00, r_q[QB][l]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else begin
            r_vf <= r_dv[QB];
        end
        rf_side <= r_side[QB];
        for (int l = 0; l < N_LANES; l++) begin
            rf_t[l] <= nf_t[l];
        end
    end

    // ---------------------------------------------------------------- stage G
    // order entry and exit per axis; a flat axis contributes [0, 1]
    logic                      r_vg;
    logic [N_AXES-1:0]         rg_ok;
    logic signed [T_WIDTH-1:0] rg_ent [N_AXES];
    logic signed [T_WIDTH-1:0] rg_ext [N_AXES];
    logic [N_AXES-1:0]         ng_ok;
    logic signed [T_WIDTH-1:0] ng_ent [N_AXES];
    logic signed [T_WIDTH-1:0] ng_ext [N_AXES];

    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            if (rf_side.flat[a]) begin
                ng_ok[a]  = rf_side.ok[a];
                ng_ent[a] = T_ZERO;
                ng_ext[a] = T_ONE;
            end else if (rf_t[2*a] > rf_t[2*a+1]) begin
                ng_ok[a]  = 1'b1;
                ng_ent[a] = rf_t[2*a+1];
                ng_ext[a] = rf_t[2*a];
            end else begin
                ng_ok[a]  = 1'b1;
                ng_ent[a] = rf_t[2*a];
                ng_ext[a] = rf_t[2*a+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vg <= 1'b0;
        end else begin
            r_vg <= r_vf;
        end
        rg_ok <= ng_ok;
        for (int a = 0; a < N_AXES; a++) begin
            rg_ent[a] <= ng_ent[a];
            rg_ext[a] <= ng_ext[a];
        end
    end

    // ---------------------------------------------------------------- stage H
    // narrowing is monotone, so the interval test reduces to the latest
    // entry against the earliest exit over all axes
    logic signed [T_WIDTH-1:0] w_tmin;
    logic signed [T_WIDTH-1:0] w_tmax;
    logic                      n_hit;
    logic                      r_valid;
    logic                      r_hit;

    always_comb begin
        w_tmin = T_ZERO;
        w_tmax = T_ONE;
        for (int a = 0; a < N_AXES; a++) begin
            if (rg_ent[a] > w_tmin) begin
                w_tmin = rg_ent[a];
            end
            if (rg_ext[a] < w_tmax) begin
                w_tmax = rg_ext[a];
            end
        end
        n_hit = (&rg_ok) && (w_tmin <= w_tmax);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vg;
        end
        r_hit <= n_hit;
    end

    assign busy    = 1'b0;
    assign o_valid = r_valid;
    assign o_hit   = r_hit;

    // ------------------------------------------------------------ assertions
`include "segment_box_intersect_top_assert.svh"

    `SBI_ASSERT_NEVER(a_never_busy, busy, "busy raised")
    `SBI_ASSERT_IMPLY(a_result_latency, o_valid, $past(start, LATENCY), "result without request")
    `SBI_ASSERT_IMPLY(a_div_feeds_out, r_vg, $past(r_dv[0], QB + 2), "divider valid lost")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment box intersect testbench
// drives segment/box requests through the slab test pipeline, predicts each hit
// flag with a fixed-point slab model or a typed table answer, checks every strobed
// result in order; a short directed table comes first, then shaped random requests
// ----------------------------------------------------------------------------
module testbench;

    localparam int CW        = 32;
    localparam int HW        = CW - 1;
    localparam int N_RANDOM  = 1100;
    localparam int DRAIN     = 60;       // well past the pipeline depth
    localparam int LIMIT     = 200000;   // cycles, far more than the slowest run takes
    localparam int Q_ONE     = 32'h0001_0000;
    localparam int T_FRACB   = 24;
    localparam longint PARAM_ONE = longint'(1) <<< T_FRACB;
    localparam longint PARAM_MAX = 64'sh7FFF_FFFF;
    localparam longint PARAM_MIN = -64'sh8000_0000;

    // one request: segment endpoints and box center / half extents, x y z
    typedef struct packed {
        logic [2:0][CW-1:0] p0;
        logic [2:0][CW-1:0] p1;
        logic [2:0][CW-1:0] ctr;
        logic [2:0][HW-1:0] half;
    } t_seg_box;

    // directed row: request plus an optional hand-read answer
    typedef struct {
        t_seg_box req;
        bit       known;
        bit       hit;
    } t_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    logic     o_valid;
    logic     o_hit;
    t_seg_box drv;

    int       mismatches;
    int       cycles;
    bit       known_q[$];   // per pending request: answer typed in the table
    bit       typed_q[$];   // the typed answer itself
    bit       hit_expect_q[$];

    segment_box_intersect_top #(.COORD_WIDTH(CW)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_start_x      (drv.p0[0]),
        .i_start_y      (drv.p0[1]),
        .i_start_z      (drv.p0[2]),
        .i_end_x        (drv.p1[0]),
        .i_end_y        (drv.p1[1]),
        .i_end_z        (drv.p1[2]),
        .i_box_center_x (drv.ctr[0]),
        .i_box_center_y (drv.ctr[1]),
        .i_box_center_z (drv.ctr[2]),
        .i_box_half_x   (drv.half[0]),
        .i_box_half_y   (drv.half[1]),
        .i_box_half_z   (drv.half[2]),
        .o_valid        (o_valid),
        .o_hit          (o_hit)
    );

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    // signed Q8.24 quotient, truncated toward zero, saturating at 128.0
    function automatic longint q824_div(longint num, longint den);
        bit     neg;
        longint an;
        longint ad;
        longint q;
        neg = (num < 0) != (den < 0);
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        if (an / ad >= 128)
            return neg ? PARAM_MIN : PARAM_MAX;
        q = (an <<< T_FRACB) / ad;
        return neg ? -q : q;
    endfunction

    // slab test: narrow [0,1] axis by axis, first empty interval is a miss
    function automatic bit slab_hit(t_seg_box r);
        longint tmin;
        longint tmax;
        longint s;
        longint e;
        longint c;
        longint h;
        longint lo;
        longint hi;
        longint d;
        longint t0;
        longint t1;
        longint tmp;
        tmin = 0;
        tmax = PARAM_ONE;
        for (int a = 0; a < 3; a++) begin
            s  = longint'($signed(r.p0[a]));
            e  = longint'($signed(r.p1[a]));
            c  = longint'($signed(r.ctr[a]));
            h  = longint'(r.half[a]);
            lo = c - h;
            hi = c + h;
            d  = e - s;
            if (d == 0) begin
                // segment does not move here: start must lie in the bounds
                if (s < lo || s > hi)
                    return 1'b0;
            end else begin
                t0 = q824_div(lo - s, d);
                t1 = q824_div(hi - s, d);
                if (t0 > t1) begin
                    tmp = t0;
                    t0  = t1;
                    t1  = tmp;
                end
                if (t0 > tmin)
                    tmin = t0;
                if (t1 < tmax)
                    tmax = t1;
                if (tmin > tmax)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_seg_box mk(int sx, int sy, int sz, int ex, int ey, int ez,
                                    int cx, int cy, int cz, int hx, int hy, int hz);
        t_seg_box r;
        r.p0   = {sz, sy, sx};
        r.p1   = {ez, ey, ex};
        r.ctr  = {cz, cy, cx};
        r.half = {hz[HW-1:0], hy[HW-1:0], hx[HW-1:0]};
        return r;
    endfunction

    function automatic t_row mk_row(t_seg_box req, bit known, bit hit);
        t_row r;
        r.req   = req;
        r.known = known;
        r.hit   = hit;
        return r;
    endfunction

    function automatic logic [CW-1:0] near_coord();
        // within about +-8.0, where most boxes and segments meet
        return CW'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    // shaped random request: mostly segments near a box, some noise
    function automatic t_seg_box random_request();
        t_seg_box r;
        int       shape;
        shape = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) begin
            case (shape)
                0, 1: begin
                    // raw noise over the whole field range
                    r.p0[a]   = $urandom;
                    r.p1[a]   = $urandom;
                    r.ctr[a]  = $urandom;
                    r.half[a] = HW'($urandom);
                end
                2: begin
                    // flat axis now and then, start near the bounds
                    r.ctr[a]  = near_coord();
                    r.half[a] = HW'($urandom_range(0, 3 * Q_ONE));
                    r.p0[a]   = r.ctr[a] + CW'(int'($urandom_range(0, 8 * Q_ONE))
                                               - 4 * Q_ONE);
                    r.p1[a]   = ($urandom_range(0, 1) == 1) ? r.p0[a] : near_coord();
                end
                3: begin
                    // segment symmetric about the center, always crosses it
                    r.ctr[a]  = $urandom;
                    r.half[a] = HW'($urandom_range(0, 1 << 16));
                    r.p0[a]   = r.ctr[a] - CW'($urandom_range(0, 1 << 24));
                    r.p1[a]   = 2 * r.ctr[a] - r.p0[a];
                end
                4: begin
                    // huge boxes and far endpoints, saturating parameters
                    r.ctr[a]  = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    r.half[a] = ($urandom_range(0, 1) == 1) ? '1 : HW'($urandom);
                    r.p0[a]   = $urandom;
                    r.p1[a]   = r.p0[a] + CW'($urandom_range(0, 3)) - 1;
                end
                default: begin
                    r.ctr[a]  = near_coord();
                    r.half[a] = HW'($urandom_range(0, 4 * Q_ONE));
                    r.p0[a]   = near_coord();
                    r.p1[a]   = near_coord();
                end
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch %s", $realtime, msg);
        mismatches++;
    endtask

    // send one request; busy is sampled mid-cycle so it matches the next edge
    task automatic send_request(t_seg_box r, bit known, bit hit, bit may_idle);
        bit was_busy;
        if (may_idle) begin
            while ($urandom_range(0, 99) < 30) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        known_q.insert(known_q.size(), known);
        typed_q.insert(typed_q.size(), hit);
        start <= 1'b1;
        drv   <= r;
        forever begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
            if (!was_busy)
                break;
        end
    endtask

    // request side: predict on acceptance, typed answer wins where given
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            if (known_q.size() == 0) begin
                report_mismatch("request accepted with none sent");
            end else begin
                if (known_q.pop_front())
                    hit_expect_q.insert(hit_expect_q.size(), typed_q.pop_front());
                else begin
                    void'(typed_q.pop_front());
                    hit_expect_q.insert(hit_expect_q.size(), slab_hit(drv));
                end
            end
        end
    end

    // result side: every strobe takes the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (hit_expect_q.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                bit want;
                want = hit_expect_q.pop_front();
                if (o_hit !== want)
                    report_mismatch($sformatf("hit: got %0b expected %0b", o_hit, want));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        mismatches = 0;
        cycles     = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        drv        = '0;

        // point at the origin inside a unit box
        rows.insert(rows.size(), mk_row(mk(0,0,0, 0,0,0, 0,0,0, Q_ONE,Q_ONE,Q_ONE), 1, 1));
        // flat x axis, start beyond the box
        rows.insert(rows.size(), mk_row(mk(2*Q_ONE,0,0, 2*Q_ONE,0,0, 0,0,0,
                                           Q_ONE,Q_ONE,Q_ONE), 1, 0));
        // flat x axis, start exactly on the upper face
        rows.insert(rows.size(), mk_row(mk(Q_ONE,0,0, Q_ONE,0,0, 0,0,0,
                                           Q_ONE,Q_ONE,Q_ONE), 1, 1));
        // crosses the box along x
        rows.insert(rows.size(), mk_row(mk(-4*Q_ONE,0,0, 4*Q_ONE,0,0, 0,0,0,
                                           Q_ONE,Q_ONE,Q_ONE), 1, 1));
        // stops short of the box
        rows.insert(rows.size(), mk_row(mk(-4*Q_ONE,0,0, -2*Q_ONE,0,0, 0,0,0,
                                           Q_ONE,Q_ONE,Q_ONE), 1, 0));
        // ends exactly on the lower face: entry parameter equals one
        rows.insert(rows.size(), mk_row(mk(-4*Q_ONE,0,0, -Q_ONE,0,0, 0,0,0,
                                           Q_ONE,Q_ONE,Q_ONE), 1, 1));
        // runs backwards through the box
        rows.insert(rows.size(), mk_row(mk(0,3*Q_ONE,0, 0,-3*Q_ONE,0, 0,0,0,
                                           Q_ONE,Q_ONE,Q_ONE), 1, 1));
        // flat z axis below the box
        rows.insert(rows.size(), mk_row(mk(0,0,-5*Q_ONE, Q_ONE,Q_ONE,-5*Q_ONE, 0,0,0,
                                           Q_ONE,Q_ONE,Q_ONE), 1, 0));
        // zero-size box, full-range diagonals through the origin
        rows.insert(rows.size(), mk_row(mk(32'h8000_0000,32'h8000_0000,32'h8000_0000,
                                           32'h7FFF_FFFF,32'h7FFF_FFFF,32'h7FFF_FFFF,
                                           0,0,0, 0,0,0), 0, 0));
        rows.insert(rows.size(), mk_row(mk(32'h7FFF_FFFF,32'h8000_0000,32'h7FFF_FFFF,
                                           32'h8000_0000,32'h7FFF_FFFF,32'h8000_0000,
                                           0,0,0, 0,0,0), 0, 0));
        // largest half extents around the extreme centers
        rows.insert(rows.size(), mk_row(mk(0,0,0, -1,-1,-1,
                                           32'h7FFF_FFFF,32'h7FFF_FFFF,32'h7FFF_FFFF,
                                           -1,-1,-1), 0, 0));
        rows.insert(rows.size(), mk_row(mk(-1,-1,-1, 1,1,1,
                                           32'h8000_0000,32'h8000_0000,32'h8000_0000,
                                           -1,-1,-1), 0, 0));
        // one-lsb step far from the box: parameters saturate
        rows.insert(rows.size(), mk_row(mk(0,0,0, 1,1,1, 100*Q_ONE,0,0,
                                           Q_ONE,Q_ONE,Q_ONE), 0, 0));
        rows.insert(rows.size(), mk_row(mk(-1,0,0, 0,1,-1, -100*Q_ONE,0,0,
                                           Q_ONE,Q_ONE,Q_ONE), 0, 0));
        // passes beside the box in y only
        rows.insert(rows.size(), mk_row(mk(-4*Q_ONE,2*Q_ONE,0, 4*Q_ONE,3*Q_ONE,0, 0,0,0,
                                           Q_ONE,Q_ONE,Q_ONE), 0, 0));
        // corner touch on a diagonal
        rows.insert(rows.size(), mk_row(mk(-2*Q_ONE,-2*Q_ONE,-2*Q_ONE, -Q_ONE,-Q_ONE,-Q_ONE,
                                           0,0,0, Q_ONE,Q_ONE,Q_ONE), 0, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_request(rows[i].req, rows[i].known, rows[i].hit, 1'b1);

        // a stretch in the middle runs back to back with no gaps
        for (int n = 0; n < N_RANDOM; n++)
            send_request(random_request(), 1'b0, 1'b0, !(n >= 400 && n < 700));
        start <= 1'b0;

        while (hit_expect_q.size() != 0 || known_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
